FILE: rtl/bch_bit_decoder_defines.svh
// assertion macros for the bch bit decoder
// used by the top level, expects aclk and aresetn in scope
`ifndef BCH_BIT_DECODER_DEFINES_SVH
`define BCH_BIT_DECODER_DEFINES_SVH

// condition must never hold outside reset
`define BBD_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(expr)) else $error(msg);

// antecedent implies consequent in the same cycle
`define BBD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: rtl/bbd_pkg.sv
// shared constants, types and galois field helpers of the bch bit decoder
// no dependencies
package bbd_pkg;

    localparam int MAX_M     = 8;
    localparam int MAX_T     = 8;
    localparam int BUF_BITS  = 256;
    localparam int NUM_SYN   = 2 * MAX_T;
    localparam int NUM_COEF  = MAX_T + 1;
    localparam int NUM_BANKS = 2;
    localparam int RAM_DEPTH = NUM_BANKS * BUF_BITS;
    localparam int RAM_AW    = $clog2(RAM_DEPTH);

    typedef enum logic [1:0] {
        CFG_FIELD_DEGREE   = 2'd0,
        CFG_CODE_LENGTH    = 2'd1,
        CFG_CORRECT_LIMIT  = 2'd2,
        CFG_MESSAGE_LENGTH = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic       bank;
        logic [3:0] m;
        logic [7:0] len;
        logic [3:0] t;
        logic [7:0] k;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    function automatic logic [8:0] prim_poly(input logic [3:0] m);
        logic [8:0] p;
        unique case (m)
            4'd5:    p = 9'h025;
            4'd6:    p = 9'h043;
            4'd7:    p = 9'h083;
            4'd8:    p = 9'h171;
            default: p = 9'h013;
        endcase
        return p;
    endfunction

    function automatic logic [7:0] gf_order(input logic [3:0] m);
        logic [8:0] v;
        v = (9'd1 << m) - 9'd1;
        return v[7:0];
    endfunction

    function automatic logic [7:0] gf_xtime(input logic [7:0] a, input logic [3:0] m);
        logic [8:0] p;
        p = {a, 1'b0};
        if (p[m]) p = p ^ prim_poly(m);
        return p[7:0];
    endfunction

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b,
                                          input logic [3:0] m);
        logic [14:0] p;
        logic [8:0]  poly;
        p    = '0;
        poly = prim_poly(m);
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p = p ^ (15'(a) << i);
        end
        for (int k = 14; k >= 4; k--) begin
            if ((k >= int'(m)) && p[k]) p = p ^ (15'(poly) << (k - int'(m)));
        end
        return p[7:0];
    endfunction

endpackage

FILE: rtl/bch_bit_decoder.sv
// top level of the binary bch bit decoder
// depends on bbd_pkg, bbd_front, bbd_queue, bbd_ram, bbd_back, bch_bit_decoder_defines.svh
//
// channel   dir  handshake            payload
// s_        in   s_tvalid/s_tready    s_tdata[0] rx_bit
// m_        out  m_tvalid/m_tready    m_tdata data/bits/count, m_tlast, m_tuser
// cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
// bits are taken one per cycle into one of two buffer banks, so one codeword is
// received while the previous one decodes; with both banks busy s_tready drops.
// decode of a codeword of length n over GF(2^m) with limit t runs a setup step,
// syndromes, berlekamp-massey and chien search, then reads and sends each output chunk.
// synchronous active-low reset clears all control state; a stalled m_ side
// holds the result word while decoding of the next chunk waits in its send step.
`include "bch_bit_decoder_defines.svh"

module bch_bit_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [0] rx_bit
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] data_byte, [11:8] bits_valid,
                                   // [15:12] corrected_count
    output logic        m_tlast,   // last_chunk
    output logic        m_tuser,   // uncorrectable
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    logic                       ram_we, ram_wdata, ram_rdata;
    logic [bbd_pkg::RAM_AW-1:0] ram_waddr, ram_raddr;
    logic                       job_push, q_pop, job_done;
    bbd_pkg::job_t              push_job, pop_job;
    bbd_pkg::q_status_t         q_stat;

    bbd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .job_push  (job_push),
        .job       (push_job),
        .job_done  (job_done)
    );

    bbd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (push_job),
        .pop      (q_pop),
        .pop_job  (pop_job),
        .status   (q_stat)
    );

    bbd_ram #(
        .WIDTH (1),
        .DEPTH (bbd_pkg::RAM_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bbd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_status  (q_stat),
        .job_in    (pop_job),
        .q_pop     (q_pop),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .job_done  (job_done),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    `BBD_ASSERT_NEVER(a_q_overflow, job_push && q_stat.full, "job queue overflow")
    `BBD_ASSERT_NEVER(a_q_underflow, q_pop && q_stat.empty, "pop from empty job queue")
    `BBD_ASSERT_IMPLY(a_bank_guard, q_stat.full, !s_tready, "bit intake open with both banks busy")

endmodule

FILE: rtl/bbd_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module bbd_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 512
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) mem[waddr] <= wdata;
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/bbd_front.sv
// front end: configuration registers, bit intake into the buffer banks, job issue
// depends on bbd_pkg
module bbd_front (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [7:0]                s_tdata,   // [0] rx_bit
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [1:0]                cfg_index,
    input  logic [7:0]                cfg_data,
    output logic                      ram_we,
    output logic [bbd_pkg::RAM_AW-1:0] ram_waddr,
    output logic                      ram_wdata,
    output logic                      job_push,
    output bbd_pkg::job_t             job,
    input  logic                      job_done
);

    logic [3:0] fd_reg, fd_next;
    logic [7:0] cl_reg, cl_next;
    logic [3:0] ct_reg, ct_next;
    logic [7:0] ml_reg, ml_next;
    logic [7:0] pos_reg, pos_next;
    logic       bank_reg, bank_next;
    logic [1:0] outst_reg, outst_next;

    logic [3:0] m_eff;
    logic [7:0] nmax, len_eff, k_eff;
    logic [3:0] t_eff;
    logic       accept, word_end;

    assign cfg_ready = 1'b1;

    always_comb begin
        fd_next = fd_reg;
        cl_next = cl_reg;
        ct_next = ct_reg;
        ml_next = ml_reg;
        if (cfg_valid) begin
            unique case (bbd_pkg::cfg_index_t'(cfg_index))
                bbd_pkg::CFG_FIELD_DEGREE:   fd_next = cfg_data[3:0];
                bbd_pkg::CFG_CODE_LENGTH:    cl_next = cfg_data;
                bbd_pkg::CFG_CORRECT_LIMIT:  ct_next = cfg_data[3:0];
                bbd_pkg::CFG_MESSAGE_LENGTH: ml_next = cfg_data;
            endcase
        end
    end

    always_comb begin
        priority if (fd_reg < 4'd4) m_eff = 4'd4;
        else if (fd_reg > 4'(bbd_pkg::MAX_M)) m_eff = 4'(bbd_pkg::MAX_M);
        else m_eff = fd_reg;
        nmax = bbd_pkg::gf_order(m_eff);
        priority if (cl_reg == 8'd0) len_eff = 8'd1;
        else if (cl_reg > nmax) len_eff = nmax;
        else len_eff = cl_reg;
        t_eff = (ct_reg > 4'(bbd_pkg::MAX_T)) ? 4'(bbd_pkg::MAX_T) : ct_reg;
        k_eff = (ml_reg > len_eff) ? len_eff : ml_reg;
    end

    assign s_tready  = outst_reg < 2'(bbd_pkg::NUM_BANKS);
    assign accept    = s_tvalid && s_tready;
    assign word_end  = accept && ((9'(pos_reg) + 9'd1) >= 9'(len_eff));
    assign ram_we    = accept;
    assign ram_waddr = {bank_reg, pos_reg};
    assign ram_wdata = s_tdata[0];
    assign job_push  = word_end;

    always_comb begin
        job.bank = bank_reg;
        job.m    = m_eff;
        job.len  = len_eff;
        job.t    = t_eff;
        job.k    = k_eff;
    end

    always_comb begin
        pos_next   = pos_reg;
        bank_next  = bank_reg;
        outst_next = outst_reg + 2'(word_end) - 2'(job_done);
        if (word_end) begin
            pos_next  = 8'd0;
            bank_next = ~bank_reg;
        end else if (accept) begin
            pos_next = pos_reg + 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fd_reg    <= 4'd8;
            cl_reg    <= 8'd255;
            ct_reg    <= 4'd2;
            ml_reg    <= 8'd239;
            pos_reg   <= 8'd0;
            bank_reg  <= 1'b0;
            outst_reg <= 2'd0;
        end else begin
            fd_reg    <= fd_next;
            cl_reg    <= cl_next;
            ct_reg    <= ct_next;
            ml_reg    <= ml_next;
            pos_reg   <= pos_next;
            bank_reg  <= bank_next;
            outst_reg <= outst_next;
        end
    end

endmodule

FILE: rtl/bbd_queue.sv
// two entry job queue between front end and decode engine
// depends on bbd_pkg
module bbd_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  bbd_pkg::job_t        push_job,
    input  logic                 pop,
    output bbd_pkg::job_t        pop_job,
    output bbd_pkg::q_status_t   status
);

    bbd_pkg::job_t ent_reg [2];
    bbd_pkg::job_t ent_next [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    assign pop_job      = ent_reg[rp_reg];
    assign status.empty = cnt_reg == 2'd0;
    assign status.full  = cnt_reg == 2'd2;

    always_comb begin
        ent_next = ent_reg;
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
        if (push) begin
            ent_next[wp_reg] = push_job;
            wp_next          = ~wp_reg;
        end
        if (pop) rp_next = ~rp_reg;
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

FILE: rtl/bbd_back.sv
// decode engine: syndromes, berlekamp-massey, chien search, chunked output
// depends on bbd_pkg
module bbd_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  bbd_pkg::q_status_t         q_status,
    input  bbd_pkg::job_t              job_in,
    output logic                       q_pop,
    output logic [bbd_pkg::RAM_AW-1:0] ram_raddr,
    input  logic                       ram_rdata,
    output logic                       job_done,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [15:0]                m_tdata,  // [7:0] data_byte, [11:8] bits_valid,
                                                 // [15:12] corrected_count
    output logic                       m_tlast,  // last_chunk
    output logic                       m_tuser   // uncorrectable
);

    localparam int NS = bbd_pkg::NUM_SYN;
    localparam int NC = bbd_pkg::NUM_COEF;
    localparam int NT = bbd_pkg::MAX_T;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b0000_0001,
        ST_SETUP  = 8'b0000_0010,
        ST_SYN    = 8'b0000_0100,
        ST_DISC   = 8'b0000_1000,
        ST_UPD    = 8'b0001_0000,
        ST_CHIEN  = 8'b0010_0000,
        ST_OUT_RD = 8'b0100_0000,
        ST_SEND   = 8'b1000_0000
    } bk_state_t;

    bk_state_t     state_reg, state_next;
    bbd_pkg::job_t job_reg, job_next;
    logic [7:0] step_reg, step_next;
    logic       rv_reg, rv_next;
    logic [7:0] rpos_reg, rpos_next;
    logic [2:0] rbit_reg, rbit_next;
    logic [7:0] alpha_reg [NS];
    logic [7:0] alpha_next [NS];
    logic [7:0] pw_reg [NS];
    logic [7:0] pw_next [NS];
    logic [7:0] syn_reg [NS];
    logic [7:0] syn_next [NS];
    logic [7:0] lam_reg [NC];
    logic [7:0] lam_next [NC];
    logic [7:0] bb_reg [NC];
    logic [7:0] bb_next [NC];
    logic [7:0] ch_reg [NC];
    logic [7:0] ch_next [NC];
    logic [7:0] loc_reg [NT];
    logic [7:0] loc_next [NT];
    logic [7:0] gam_reg, gam_next, delta_reg, delta_next;
    logic [4:0] ll_reg, ll_next, r_reg, r_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       bad_reg, bad_next;
    logic [7:0] opos_reg, opos_next, rem_reg, rem_next;
    logic [3:0] rdb_reg, rdb_next;
    logic [7:0] byte_reg, byte_next;
    logic       mv_reg, mv_next;
    logic [15:0] md_reg, md_next;
    logic       ml_reg, ml_next, mu_reg, mu_next;

    logic [3:0] nb;
    logic [4:0] two_t, sidx;
    logic [7:0] nfield, chsum, cn;
    logic       sw, flip, chien_init, out_init;

    assign nb     = (rem_reg > 8'd8) ? 4'd8 : rem_reg[3:0];
    assign two_t  = {job_reg.t, 1'b0};
    assign nfield = bbd_pkg::gf_order(job_reg.m);
    assign sidx   = r_reg - {1'b0, step_reg[3:0]};

    assign ram_raddr = (state_reg == ST_SYN) ? {job_reg.bank, step_reg}
                                             : {job_reg.bank, opos_reg};

    always_comb begin
        flip = 1'b0;
        for (int q = 0; q < NT; q++) begin
            if ((4'(q) < cnt_reg) && (loc_reg[q] == rpos_reg)) flip = 1'b1;
        end
        flip = flip && !bad_reg;
    end

    always_comb begin
        state_next = state_reg;
        job_next   = job_reg;
        step_next  = step_reg;
        rv_next    = 1'b0;
        rpos_next  = rpos_reg;
        rbit_next  = rbit_reg;
        alpha_next = alpha_reg;
        pw_next    = pw_reg;
        syn_next   = syn_reg;
        lam_next   = lam_reg;
        bb_next    = bb_reg;
        ch_next    = ch_reg;
        loc_next   = loc_reg;
        gam_next   = gam_reg;
        delta_next = delta_reg;
        ll_next    = ll_reg;
        r_next     = r_reg;
        cnt_next   = cnt_reg;
        bad_next   = bad_reg;
        opos_next  = opos_reg;
        rem_next   = rem_reg;
        rdb_next   = rdb_reg;
        byte_next  = byte_reg;
        mv_next    = mv_reg && !m_tready;
        md_next    = md_reg;
        ml_next    = ml_reg;
        mu_next    = mu_reg;
        q_pop      = 1'b0;
        job_done   = 1'b0;
        sw         = 1'b0;
        chsum      = 8'd0;
        cn         = 8'd0;
        chien_init = 1'b0;
        out_init   = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (!q_status.empty) begin
                    q_pop      = 1'b1;
                    job_next   = job_in;
                    step_next  = 8'd0;
                    gam_next   = 8'd1;
                    delta_next = 8'd0;
                    ll_next    = 5'd0;
                    r_next     = 5'd0;
                    cnt_next   = 4'd0;
                    bad_next   = 1'b0;
                    for (int i = 0; i < NS; i++) begin
                        alpha_next[i] = 8'd1;
                        pw_next[i]    = 8'd1;
                        syn_next[i]   = 8'd0;
                    end
                    for (int i = 0; i < NC; i++) begin
                        lam_next[i] = (i == 0) ? 8'd1 : 8'd0;
                        bb_next[i]  = (i == 0) ? 8'd1 : 8'd0;
                    end
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP: begin
                // lane i ends at alpha^(i+1)
                for (int i = 0; i < NS; i++) begin
                    if (step_reg[3:0] <= 4'(i))
                        alpha_next[i] = bbd_pkg::gf_xtime(alpha_reg[i], job_reg.m);
                end
                step_next = step_reg + 8'd1;
                if (step_reg == 8'(NS - 1)) begin
                    step_next  = 8'd0;
                    state_next = ST_SYN;
                end
            end
            ST_SYN: begin
                if (rv_reg) begin
                    for (int i = 0; i < NS; i++) begin
                        if (ram_rdata) syn_next[i] = syn_reg[i] ^ pw_reg[i];
                        pw_next[i] = bbd_pkg::gf_mul(pw_reg[i], alpha_reg[i], job_reg.m);
                    end
                end
                if (step_reg < job_reg.len) begin
                    rv_next   = 1'b1;
                    step_next = step_reg + 8'd1;
                end else if (job_reg.t == 4'd0) begin
                    chien_init = 1'b1;
                end else begin
                    step_next  = 8'd0;
                    state_next = ST_DISC;
                end
            end
            ST_DISC: begin
                if ({1'b0, step_reg[3:0]} <= r_reg)
                    delta_next = delta_reg ^ bbd_pkg::gf_mul(lam_reg[step_reg[3:0]],
                                                             syn_reg[sidx[3:0]], job_reg.m);
                step_next = step_reg + 8'd1;
                if (step_reg == 8'(NC - 1)) state_next = ST_UPD;
            end
            ST_UPD: begin
                sw = (delta_reg != 8'd0) && ({ll_reg, 1'b0} <= {1'b0, r_reg});
                for (int i = 0; i < NC; i++) begin
                    lam_next[i] = bbd_pkg::gf_mul(gam_reg, lam_reg[i], job_reg.m);
                    if (i > 0)
                        lam_next[i] = lam_next[i]
                                    ^ bbd_pkg::gf_mul(delta_reg, bb_reg[i-1], job_reg.m);
                    if (sw) bb_next[i] = lam_reg[i];
                    else bb_next[i] = (i > 0) ? bb_reg[i-1] : 8'd0;
                end
                if (sw) begin
                    ll_next  = r_reg + 5'd1 - ll_reg;
                    gam_next = delta_reg;
                end
                r_next = r_reg + 5'd1;
                priority if (ll_next > {1'b0, job_reg.t}) begin
                    bad_next = 1'b1;
                    out_init = 1'b1;
                end else if (r_next == two_t) begin
                    chien_init = 1'b1;
                end else begin
                    step_next  = 8'd0;
                    delta_next = 8'd0;
                    state_next = ST_DISC;
                end
            end
            ST_CHIEN: begin
                for (int j = 0; j < NC; j++) begin
                    cn = (j == 0) ? ch_reg[0]
                                  : bbd_pkg::gf_mul(ch_reg[j], alpha_reg[j-1], job_reg.m);
                    ch_next[j] = cn;
                    chsum      = chsum ^ cn;
                end
                if (chsum == 8'd0) begin
                    if (cnt_reg < 4'(NT)) loc_next[cnt_reg[2:0]] = nfield - step_reg;
                    if (cnt_reg != 4'hf) cnt_next = cnt_reg + 4'd1;
                end
                step_next = step_reg + 8'd1;
                if (step_reg == nfield) begin
                    bad_next = {1'b0, cnt_next} != ll_reg;
                    out_init = 1'b1;
                end
            end
            ST_OUT_RD: begin
                if (rv_reg) byte_next[rbit_reg] = ram_rdata ^ flip;
                if (rdb_reg < nb) begin
                    rv_next   = 1'b1;
                    rpos_next = opos_reg;
                    rbit_next = rdb_reg[2:0];
                    opos_next = opos_reg + 8'd1;
                    rdb_next  = rdb_reg + 4'd1;
                end else begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND: begin
                if (!mv_reg || m_tready) begin
                    mv_next  = 1'b1;
                    md_next  = {(bad_reg ? 4'd0 : cnt_reg), nb, byte_reg};
                    ml_next  = rem_reg <= 8'd8;
                    mu_next  = bad_reg;
                    rem_next = rem_reg - 8'(nb);
                    if (rem_reg <= 8'd8) begin
                        job_done   = 1'b1;
                        state_next = ST_IDLE;
                    end else begin
                        rdb_next   = 4'd0;
                        byte_next  = 8'd0;
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (chien_init) begin
            ch_next    = lam_next;
            step_next  = 8'd1;
            cnt_next   = 4'd0;
            state_next = ST_CHIEN;
        end
        if (out_init) begin
            opos_next  = job_reg.len - job_reg.k;
            rem_next   = job_reg.k;
            rdb_next   = 4'd0;
            byte_next  = 8'd0;
            state_next = ST_OUT_RD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            rv_reg    <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
            mv_reg    <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg   <= job_next;
        step_reg  <= step_next;
        rpos_reg  <= rpos_next;
        rbit_reg  <= rbit_next;
        alpha_reg <= alpha_next;
        pw_reg    <= pw_next;
        syn_reg   <= syn_next;
        lam_reg   <= lam_next;
        bb_reg    <= bb_next;
        ch_reg    <= ch_next;
        loc_reg   <= loc_next;
        gam_reg   <= gam_next;
        delta_reg <= delta_next;
        ll_reg    <= ll_next;
        r_reg     <= r_next;
        cnt_reg   <= cnt_next;
        bad_reg   <= bad_next;
        opos_reg  <= opos_next;
        rem_reg   <= rem_next;
        rdb_reg   <= rdb_next;
        byte_reg  <= byte_next;
        md_reg    <= md_next;
        ml_reg    <= ml_next;
        mu_reg    <= mu_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_reg;
    assign m_tlast  = ml_reg;
    assign m_tuser  = mu_reg;

endmodule

FILE: verif/bch_bit_decoder_test.sv
// self-checking testbench for bch_bit_decoder: real bch codewords plus bit errors and noise
// are streamed in, every output word is checked against an in-bench bch decoder model
// depends on bbd_pkg and the bch_bit_decoder rtl
`timescale 1ns / 1ps

module bch_bit_decoder_test;

    localparam int STALL_LIMIT = 20000;
    localparam int DRAIN_WAIT  = 1000;
    localparam int TT          = 2 * bbd_pkg::MAX_T + 2;

    typedef struct {
        logic [7:0] data;
        logic [3:0] nbits;
        logic       last;
        logic [3:0] fixed;
        logic       unc;
    } chunk_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [7:0]  cfg_data = '0;

    // decoder model state
    int     reg_m = 8, reg_len = 255, reg_t = 2, reg_k = 239;
    bit     rx_bits [256];
    int     rx_pos = 0;
    chunk_t expected_chunks [$];

    int     gexp [256];
    int     glog [256];
    int     gn;
    bit     word_bits [256];

    bit     calm = 1'b0;
    int     fails = 0, words_sent = 0, chunks_checked = 0, bits_sent = 0;
    int     stall_cycles = 0;

    bch_bit_decoder i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tlast(m_tlast), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int eff_m();
        return (reg_m < 4) ? 4 : (reg_m > bbd_pkg::MAX_M) ? bbd_pkg::MAX_M : reg_m;
    endfunction

    function automatic int eff_len();
        int n;
        n = reg_len;
        if (n > (1 << eff_m()) - 1) n = (1 << eff_m()) - 1;
        if (n < 1) n = 1;
        return n;
    endfunction

    function automatic void build_field(int m);
        int v;
        v  = 1;
        gn = (1 << m) - 1;
        for (int i = 0; i < 256; i++) glog[i] = -1;
        for (int i = 0; i < gn; i++) begin
            gexp[i] = v;
            glog[v] = i;
            v = v << 1;
            if (v & (1 << m)) begin
                case (m)
                    5: v = v ^ 'h25;
                    6: v = v ^ 'h43;
                    7: v = v ^ 'h83;
                    8: v = v ^ 'h171;
                    default: v = v ^ 'h13;
                endcase
            end
            v = v & 255;
        end
    endfunction

    function automatic int gmul(int a, int b);
        if (a == 0 || b == 0) return 0;
        return gexp[(glog[a] + glog[b]) % gn];
    endfunction

    function automatic int gdiv(int a, int b);
        if (a == 0 || b == 0) return 0;
        return gexp[(glog[a] + gn - glog[b]) % gn];
    endfunction

    // berlekamp iteration and chien search, corrects rx_bits; -1 when uncorrectable
    function automatic int correct_word(int len, int t);
        int s [TT];
        int dv [TT];
        int elp [TT][TT];
        int lv [TT];
        int ulu [TT];
        int locs [256];
        int t2, u, q, j, d, sum, count;
        bit err;
        t2 = 2 * t;
        err = 1'b0;
        count = 0;
        for (int i = 0; i < TT; i++) begin
            s[i] = 0; dv[i] = 0; lv[i] = 0; ulu[i] = 0;
            for (int c = 0; c < TT; c++) elp[i][c] = 0;
        end
        for (int i = 1; i <= t2; i++) begin
            for (int p = 0; p < len; p++)
                if (rx_bits[p]) s[i] = s[i] ^ gexp[(i * p) % gn];
            if (s[i] != 0) err = 1'b1;
        end
        if (!err) return 0;
        dv[0] = 1; dv[1] = s[1];
        elp[0][0] = 1; elp[1][0] = 1;
        ulu[0] = -1;
        u = 0;
        do begin
            u++;
            if (dv[u] == 0) begin
                lv[u + 1] = lv[u];
                for (int c = 0; c < TT; c++) elp[u + 1][c] = elp[u][c];
            end else begin
                q = u - 1;
                while (dv[q] == 0 && q > 0) q--;
                if (q > 0) begin
                    j = q;
                    do begin
                        j--;
                        if (dv[j] != 0 && ulu[q] < ulu[j]) q = j;
                    end while (j > 0);
                end
                lv[u + 1] = (lv[u] > lv[q] + u - q) ? lv[u] : lv[q] + u - q;
                for (int c = 0; c < TT; c++) elp[u + 1][c] = 0;
                for (int i = 0; i <= lv[q]; i++)
                    if (i + u - q < TT)
                        elp[u + 1][i + u - q] = gmul(dv[u], gdiv(elp[q][i], dv[q]));
                for (int i = 0; i <= lv[u] && i < TT; i++)
                    elp[u + 1][i] = elp[u + 1][i] ^ elp[u][i];
            end
            ulu[u + 1] = u - lv[u + 1];
            if (u < t2) begin
                d = s[u + 1];
                for (int i = 1; i <= lv[u + 1] && i < TT; i++)
                    if (u + 1 - i >= 1) d = d ^ gmul(s[u + 1 - i], elp[u + 1][i]);
                dv[u + 1] = d;
            end
        end while (u < t2 && lv[u + 1] <= t);
        u++;
        if (lv[u] > t) return -1;
        for (int i = 1; i <= gn; i++) begin
            sum = 1;
            for (int c = 1; c <= lv[u]; c++)
                sum = sum ^ gmul(elp[u][c], gexp[(i * c) % gn]);
            if (sum == 0) begin
                locs[count] = gn - i;
                count++;
            end
        end
        if (count != lv[u]) return -1;
        for (int i = 0; i < count; i++)
            if (locs[i] < len) rx_bits[locs[i]] = ~rx_bits[locs[i]];
        return count;
    endfunction

    function automatic void take_rx_bit(bit b);
        int len, t, k, res, i, nb;
        bit bad;
        chunk_t c;
        len = eff_len();
        rx_bits[rx_pos % 256] = b;
        rx_pos = (rx_pos + 1) & 255;
        if (rx_pos < len) return;
        rx_pos = 0;
        t = (reg_t > bbd_pkg::MAX_T) ? bbd_pkg::MAX_T : reg_t;
        k = (reg_k > len) ? len : reg_k;
        build_field(eff_m());
        res = correct_word(len, t);
        bad = (res < 0);
        if (bad) res = 0;
        i = 0;
        do begin
            nb = (k - i > 8) ? 8 : k - i;
            c.data = '0;
            for (int p = 0; p < nb; p++) c.data[p] = rx_bits[len - k + i + p];
            i += nb;
            c.nbits = nb[3:0];
            c.last  = (i >= k);
            c.fixed = res[3:0];
            c.unc   = bad;
            expected_chunks.push_back(c);
        end while (i < k);
    endfunction

    // codeword = random message times generator, or random bits when noise is set, plus nerr flipped bits
    function automatic void make_word(int len, int t, int nerr, bit noise);
        bit isroot [256];
        int g [257];
        int deg, j;
        deg = 0;
        build_field(eff_m());
        for (int i = 0; i < 256; i++) begin
            isroot[i] = 1'b0;
            word_bits[i] = 1'b0;
            g[i] = 0;
        end
        g[256] = 0;
        g[0] = 1;
        for (int i = 1; i <= 2 * t; i++) begin
            j = i % gn;
            do begin
                isroot[j] = 1'b1;
                j = (2 * j) % gn;
            end while (j != i % gn);
        end
        for (int r = 0; r < gn; r++) begin
            if (isroot[r]) begin
                for (int c = deg + 1; c >= 0; c--)
                    g[c] = ((c > 0) ? g[c - 1] : 0) ^ gmul(g[c], gexp[r]);
                deg++;
            end
        end
        if (noise) begin
            for (int i = 0; i < len; i++) word_bits[i] = $urandom_range(1);
        end else if (len > deg) begin
            for (int i = 0; i < len - deg; i++)
                if ($urandom_range(1))
                    for (int c = 0; c <= deg; c++) word_bits[i + c] ^= g[c][0];
        end
        for (int e = 0; e < nerr; e++) begin
            j = $urandom_range(len - 1);
            word_bits[j] = ~word_bits[j];
        end
    endfunction

    task automatic send_bit(bit b);
        if (!calm && $urandom_range(99) < 8) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'($urandom), b};
        do @(posedge aclk); while (!s_tready);
        take_rx_bit(b);
        bits_sent++;
    endtask

    task automatic send_word(int nerr, bit noise);
        int len, t;
        len = eff_len();
        t = (reg_t > bbd_pkg::MAX_T) ? bbd_pkg::MAX_T : reg_t;
        make_word(len, t, nerr, noise);
        for (int i = 0; i < len; i++) send_bit(word_bits[i]);
        words_sent++;
    endtask

    task automatic write_reg(bbd_pkg::cfg_index_t idx, logic [7:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            bbd_pkg::CFG_FIELD_DEGREE:  reg_m = val[3:0];
            bbd_pkg::CFG_CODE_LENGTH:   reg_len = val;
            bbd_pkg::CFG_CORRECT_LIMIT: reg_t = val[3:0];
            default:                    reg_k = val;
        endcase
    endtask

    task automatic set_regs(int m, int len, int t, int k);
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_chunks.size() != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        write_reg(bbd_pkg::CFG_FIELD_DEGREE, m[7:0]);
        write_reg(bbd_pkg::CFG_CODE_LENGTH, len[7:0]);
        write_reg(bbd_pkg::CFG_CORRECT_LIMIT, t[7:0]);
        write_reg(bbd_pkg::CFG_MESSAGE_LENGTH, k[7:0]);
        cfg_valid <= 1'b0;
    endtask

    // field, limit and message length stay at reset values
    task automatic test_reset_defaults();
        write_reg(bbd_pkg::CFG_CODE_LENGTH, 8'd24);
        cfg_valid <= 1'b0;
        send_word(2, 1'b0);
    endtask

    task automatic test_small_field();
        set_regs(4, 15, 2, 7);
        for (int e = 1; e <= 3; e++) send_word(e, 1'b0);
    endtask

    task automatic test_degenerate_settings();
        set_regs(0, 0, 0, 0);
        send_bit(1'b1);
        send_bit(1'b0);
        set_regs(4, 20, 1, 15);
        send_word(1, 1'b0);
    endtask

    task automatic test_strongest_code();
        set_regs(15, 66, 15, 66);
        send_word(8, 1'b0);
        set_regs(6, 50, 8, 50);
        send_word(9, 1'b0);
    endtask

    task automatic test_config_mid_word();
        set_regs(5, 31, 3, 21);
        make_word(31, 3, 0, 1'b1);
        for (int i = 0; i < 10; i++) send_bit(word_bits[i]);
        set_regs(5, 6, 3, 4);
        send_bit(1'b1);
        set_regs(5, 31, 3, 21);
        send_word(3, 1'b0);
    endtask

    task automatic test_random_words();
        int m, len, t, phase;
        phase = 0;
        while (bits_sent < 270) begin
            m   = $urandom_range(4, 8);
            len = $urandom_range(1) ? (1 << m) - 1 : $urandom_range(1, 24);
            if (m > 5 && len > 24) len = 24;
            t   = $urandom_range(1, 4);
            set_regs(m, len, t, $urandom_range(0, eff_len()));
            calm = (phase == 0);
            repeat ($urandom_range(2, 4))
                send_word($urandom_range(0, t + 1), $urandom_range(99) < 20);
            calm = 1'b0;
            phase++;
        end
    endtask

    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(99) >= 8);
    end

    always @(posedge aclk) begin
        chunk_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_chunks.size() == 0) begin
                $display("%0t: unexpected word %h last %b user %b",
                         $time, m_tdata, m_tlast, m_tuser);
                fails++;
            end else begin
                e = expected_chunks.pop_front();
                chunks_checked++;
                if (m_tdata[7:0] !== e.data || m_tdata[11:8] !== e.nbits ||
                    m_tlast !== e.last || m_tdata[15:12] !== e.fixed || m_tuser !== e.unc) begin
                    $display("%0t: expected data %h bits %0d last %b count %0d unc %b",
                             $time, e.data, e.nbits, e.last, e.fixed, e.unc);
                    $display("%0t: actual   data %h bits %0d last %b count %0d unc %b",
                             $time, m_tdata[7:0], m_tdata[11:8], m_tlast,
                             m_tdata[15:12], m_tuser);
                    fails++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_defaults();
        test_small_field();
        test_degenerate_settings();
        test_strongest_code();
        test_config_mid_word();
        test_random_words();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (expected_chunks.size() != 0);
        repeat (DRAIN_WAIT) @(posedge aclk);
        $display("covered %0d codewords, %0d bits in, %0d output words checked",
                 words_sent, bits_sent, chunks_checked);
        $display("fields 4..8, shortened and degenerate lengths, up to 9 bit errors");
        if (fails == 0 && expected_chunks.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

FILE: bch_bit_decoder.f
+incdir+rtl
rtl/bbd_pkg.sv
rtl/bbd_ram.sv
rtl/bbd_front.sv
rtl/bbd_queue.sv
rtl/bbd_back.sv
rtl/bch_bit_decoder.sv
verif/bch_bit_decoder_test.sv
